// File: design/b64enc_pkg.sv
// Shared types, constants and the alphabet mapping of the base64 encoder.
`default_nettype none
package b64enc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    // Configuration register indexes
    localparam logic CFG_URL_SAFE = 1'b0;
    localparam logic CFG_PAD_EN   = 1'b1;

    // One group of one to three bytes, stamped with the settings it is encoded under
    typedef struct packed {
        logic [23:0] bits;     // first byte in bits 23..16, missing bytes zero
        logic [1:0]  nbytes;   // 1 to 3
        logic        is_end;
        logic        pad;
        logic        url;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic url_safe;
        logic pad_en;
    } t_cfg;

    function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
        logic [5:0] s;
        logic [7:0] c;
        begin
            s = v & SEXTET_MASK;
            if (s < 6'd26) begin
                c = 8'h41 + {2'b00, s};
            end else if (s < 6'd52) begin
                c = 8'h61 + {2'b00, s - 6'd26};
            end else if (s < 6'd62) begin
                c = 8'h30 + {2'b00, s - 6'd52};
            end else if (s == 6'd62) begin
                c = url ? 8'h2D : 8'h2B;
            end else begin
                c = url ? 8'h5F : 8'h2F;
            end
            return c;
        end
    endfunction

endpackage
`default_nettype wire

// File: design/b64enc_front.sv
// Front end: accepts message bytes and packs them into groups for the queue.
`default_nettype none
module b64enc_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire [7:0]           i_data_byte,
    input  wire                 i_message_end,
    input  b64enc_pkg::t_cfg    i_cfg,
    output logic                o_push,
    output b64enc_pkg::t_group  o_group
);

    logic [15:0] r_held, n_held;
    logic [1:0]  r_cnt, n_cnt;

    always_comb begin
        n_held = r_held;
        n_cnt  = r_cnt;
        o_push = 1'b0;
        o_group.nbytes = r_cnt + 2'd1;
        o_group.is_end = i_message_end;
        o_group.pad    = i_cfg.pad_en;
        o_group.url    = i_cfg.url_safe;
        case (r_cnt)
            2'd0:    o_group.bits = {i_data_byte, 16'h0000};
            2'd1:    o_group.bits = {r_held[15:8], i_data_byte, 8'h00};
            default: o_group.bits = {r_held, i_data_byte};
        endcase
        if (i_accept) begin
            if (!i_message_end && r_cnt < 2'd2) begin
                // hold the byte until the group fills or the message ends
                if (r_cnt == 2'd0) begin
                    n_held = {i_data_byte, 8'h00};
                end else begin
                    n_held = {r_held[15:8], i_data_byte};
                end
                n_cnt = r_cnt + 2'd1;
            end else begin
                o_push = 1'b1;
                n_held = 16'h0000;
                n_cnt  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 16'h0000;
            r_cnt  <= 2'd0;
        end else begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// File: design/b64enc_fifo.sv
// Two-entry group queue between the front end and the character serializer.
`default_nettype none
module b64enc_fifo (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  b64enc_pkg::t_group       i_group,
    input  wire                      i_pop,
    output b64enc_pkg::t_group       o_group,
    output b64enc_pkg::t_q_status    o_status
);

    b64enc_pkg::t_group r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;

    assign o_group        = r_mem[r_rptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: design/b64enc_back.sv
// Back end: turns one queued group into characters, one per cycle unless stalled, into an output register.
`default_nettype none
module b64enc_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  b64enc_pkg::t_group       i_group,
    input  b64enc_pkg::t_q_status    i_q_status,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output logic [7:0]               o_out_char,
    output logic                     o_out_last
);

    b64enc_pkg::t_group r_grp;
    logic       r_busy;
    logic [1:0] r_k;
    logic       r_ovalid;
    logic [7:0] r_ochar;
    logic       r_olast;

    logic       can_load;
    logic       at_last;
    logic [1:0] last_k;
    logic [5:0] sextet;
    logic [7:0] char_now;

    assign can_load = !r_ovalid || i_out_ready;
    assign last_k   = r_grp.pad ? 2'd3 : r_grp.nbytes;
    assign at_last  = (r_k == last_k);
    assign o_pop    = !i_q_status.empty && (!r_busy || (can_load && at_last));

    always_comb begin
        case (r_k)
            2'd0:    sextet = r_grp.bits[23:18];
            2'd1:    sextet = r_grp.bits[17:12];
            2'd2:    sextet = r_grp.bits[11:6];
            default: sextet = r_grp.bits[5:0];
        endcase
        // positions past the last data byte are pad
        if (r_k > r_grp.nbytes) begin
            char_now = b64enc_pkg::PAD_CHAR;
        end else begin
            char_now = b64enc_pkg::sextet_char(sextet, r_grp.url);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (r_busy && can_load) begin
            r_ochar <= char_now;
            r_olast <= r_grp.is_end && at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_k      <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (can_load) begin
                r_ovalid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (r_busy && can_load) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_char  = r_ochar;
    assign o_out_last  = r_olast;

endmodule
`default_nettype wire

// File: design/base64_stream_encoder.sv
// Top level of the streaming base64 encoder: config registers, front, queue, back.
`default_nettype none
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one message byte per
//   transaction, with i_message_end set on the final byte of a message.
//   Output channel (o_out_valid / i_out_ready) carries one character per
//   transaction; o_out_last marks the final character of a message.
//   Config port: write i_cfg_data to register i_cfg_index while i_cfg_we is
//   high (index 0 selects the URL-safe alphabet, index 1 enables '=' pad).
//   Write it only while the block is idle.
// Timing:
//   A byte is taken every cycle while the two-entry group queue has room.
//   The serializer emits one character per cycle while i_out_ready allows;
//   a padded or full group gives four characters, and a short final group
//   without pad gives two or three.
//   The byte that completes a group goes into the queue, then into the
//   serializer's group register, before its first character is registered.
// Reset (synchronous, active low) empties the queue and held bytes, drops
//   any pending output, and restores standard alphabet with pad enabled.
// A stalled receiver holds the output register; the queue absorbs two more
//   groups before o_in_ready drops.
module base64_stream_encoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_message_end,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_out_last,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire         i_cfg_data
);

    b64enc_pkg::t_cfg      r_cfg;
    b64enc_pkg::t_group    front_group;
    b64enc_pkg::t_group    q_group;
    b64enc_pkg::t_q_status q_status;
    logic                  in_accept;
    logic                  push;
    logic                  pop;

    // Take a byte whenever the queue can absorb a group it might complete
    assign o_in_ready = !q_status.full;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.url_safe <= 1'b0;
            r_cfg.pad_en   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                b64enc_pkg::CFG_URL_SAFE: r_cfg.url_safe <= i_cfg_data;
                b64enc_pkg::CFG_PAD_EN:   r_cfg.pad_en   <= i_cfg_data;
                default:                  r_cfg          <= r_cfg;
            endcase
        end
    end

    b64enc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_data_byte   (i_data_byte),
        .i_message_end (i_message_end),
        .i_cfg         (r_cfg),
        .o_push        (push),
        .o_group       (front_group)
    );

    b64enc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_group  (front_group),
        .i_pop    (pop),
        .o_group  (q_group),
        .o_status (q_status)
    );

    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_group     (q_group),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_out_last  (o_out_last)
    );

    // Queue cannot be full and empty at once
    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("group queue full and empty together");

    // Nothing is offered right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A pad that is not last is always followed at once by another pad
    a_pad_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_last && o_out_char == b64enc_pkg::PAD_CHAR)
        |=> (o_out_valid && o_out_char == b64enc_pkg::PAD_CHAR && o_out_last))
        else $error("pad run broken");

    // No push into a full queue unless a pop happens in the same cycle
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && q_status.full) |-> pop)
        else $error("group pushed into full queue");

endmodule
`default_nettype wire
